// ----- sv/mdet_pkg.sv -----
// Shared types, constants and permutation tables of the matrix determinant block.
package mdet_pkg;

    localparam int ENTRY_W       = 12;
    localparam int DET_W         = 54;
    localparam int SIZE_W        = 3;
    localparam int MDET_MAX_SIZE = 4;
    localparam int TABLE_MAX     = 4;
    localparam int STORE_AW      = $clog2(TABLE_MAX * TABLE_MAX);
    localparam int NUM_BANKS     = 2;
    localparam int TERM_W        = 5;
    localparam int S_TDATA_W     = ((ENTRY_W + 7) / 8) * 8;
    localparam int M_TDATA_W     = ((DET_W + 7) / 8) * 8;

    typedef logic signed [ENTRY_W-1:0] entry_t;
    typedef logic signed [DET_W-1:0]   det_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
    } job_t;

    typedef struct packed {
        logic                en;
        logic                bank;
        logic [STORE_AW-1:0] addr;
        entry_t              data;
    } store_wr_t;

    // Each entry is {negative, column of row 3, row 2, row 1, row 0}.
    localparam logic [8:0] PERM2 [2] = '{9'h004, 9'h101};

    localparam logic [8:0] PERM3 [8] = '{
        9'h024, 9'h118, 9'h121, 9'h009, 9'h012, 9'h106, 9'h000, 9'h000
    };

    localparam logic [8:0] PERM4 [32] = '{
        9'h0E4, 9'h1B4, 9'h1D8, 9'h078, 9'h09C, 9'h16C,
        9'h1E1, 9'h0B1, 9'h0C9, 9'h139, 9'h18D, 9'h02D,
        9'h0D2, 9'h172, 9'h1C6, 9'h036, 9'h04E, 9'h11E,
        9'h193, 9'h063, 9'h087, 9'h127, 9'h14B, 9'h01B,
        9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000
    };

    function automatic logic [8:0] perm_entry(input logic [SIZE_W-1:0] size,
                                              input logic [TERM_W-1:0] term);
        logic [8:0] res;
        unique case (size)
            SIZE_W'(2): res = PERM2[term[0]];
            SIZE_W'(3): res = PERM3[term[2:0]];
            default:    res = PERM4[term];
        endcase
        return res;
    endfunction

    function automatic logic [TERM_W-1:0] term_count(input logic [SIZE_W-1:0] size);
        logic [TERM_W-1:0] res;
        unique case (size)
            SIZE_W'(2): res = TERM_W'(2);
            SIZE_W'(3): res = TERM_W'(6);
            default:    res = TERM_W'(24);
        endcase
        return res;
    endfunction

endpackage

// ----- sv/mdet_front.sv -----
// Front end: takes the size register and matrix entries and hands full matrices to the queue.
module mdet_front
    import mdet_pkg::*;
#(
    parameter int MAX_SIZE = MDET_MAX_SIZE
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic              s_tvalid,
    input  entry_t            s_entry,
    output logic              s_tready,
    input  logic              q_full,
    output logic              q_push,
    output job_t              q_job,
    output store_wr_t         wr
);

    localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              wbank_reg, wbank_next;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  cnt_inc;
    logic [SIZE_W-1:0] cfg_size;
    logic              accept;
    logic              last;

    assign total    = CNT_W'(size_reg) * CNT_W'(size_reg);
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign s_tready = !q_full && !cfg_valid;
    assign accept   = s_tvalid && s_tready;
    assign last     = (cnt_inc == total);

    always_comb
    begin
        if (cfg_data < SIZE_W'(2))
        begin
            cfg_size = SIZE_W'(2);
        end
        else if (cfg_data > SIZE_W'(MAX_SIZE))
        begin
            cfg_size = SIZE_W'(MAX_SIZE);
        end
        else
        begin
            cfg_size = cfg_data;
        end
    end

    always_comb
    begin
        size_next  = size_reg;
        cnt_next   = cnt_reg;
        wbank_next = wbank_reg;
        if (cfg_valid)
        begin
            size_next = cfg_size;
            cnt_next  = '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                cnt_next   = '0;
                wbank_next = !wbank_reg;
            end
            else
            begin
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= SIZE_W'(2);
            cnt_reg   <= '0;
            wbank_reg <= 1'b0;
        end
        else
        begin
            size_reg  <= size_next;
            cnt_reg   <= cnt_next;
            wbank_reg <= wbank_next;
        end
    end

    assign q_push     = accept && last;
    assign q_job.size = size_reg;

    assign wr.en   = accept;
    assign wr.bank = wbank_reg;
    assign wr.addr = STORE_AW'(cnt_reg[ADDR_W-1:0]);
    assign wr.data = s_entry;

endmodule

// ----- sv/mdet_queue.sv -----
// Small job queue between the loading front end and the compute back end.
module mdet_queue
    import mdet_pkg::*;
#(
    parameter int DEPTH = NUM_BANKS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic valid,
    output logic full
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    job_t               slot_reg [DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    assign valid = (count_reg != '0);
    assign full  = (count_reg == COUNT_W'(DEPTH));
    assign head  = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_job;
        end
    end

endmodule

// ----- sv/mdet_back.sv -----
// Back end: matrix store and a shared multiply-accumulate that sums the permutation terms.
module mdet_back
    import mdet_pkg::*;
#(
    parameter int MAX_SIZE = MDET_MAX_SIZE
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  store_wr_t wr,
    input  logic      q_valid,
    input  job_t      q_head,
    output logic      q_pop,
    output logic      m_tvalid,
    input  logic      m_tready,
    output det_t      m_det
);

    localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W  = $clog2(MAX_SIZE);
    localparam int PROD_W = ENTRY_W * MAX_SIZE;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    typedef struct packed {
        logic valid;
        logic first;
        logic last_row;
        logic neg;
        logic last_term;
    } pipe_t;

    entry_t matrix_mem [NUM_BANKS][DEPTH];

    logic [1:0]                state_reg, state_next;
    logic [TERM_W-1:0]         term_reg, term_next;
    logic [ROW_W-1:0]          row_reg, row_next;
    logic                      rbank_reg, rbank_next;
    logic                      out_valid_reg, out_valid_next;
    pipe_t                     c1_reg, c1_next;
    pipe_t                     c2_reg;
    entry_t                    rd_data_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    det_t                      acc_reg;
    det_t                      out_data_reg;

    logic [8:0]                perm;
    logic [1:0]                col;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      last_row;
    logic                      last_term;
    logic                      start;
    logic                      done;
    logic signed [PROD_W+ENTRY_W-1:0] mult_full;
    det_t                      prod_ext;
    det_t                      acc_sum;

    assign perm      = perm_entry(q_head.size, term_reg);
    assign col       = 2'(perm[7:0] >> {row_reg, 1'b0});
    assign rd_addr   = ADDR_W'(row_reg) * ADDR_W'(q_head.size) + ADDR_W'(col);
    assign last_row  = (row_reg == ROW_W'(q_head.size - SIZE_W'(1)));
    assign last_term = (term_reg == term_count(q_head.size) - TERM_W'(1));
    assign start     = (state_reg == S_IDLE) && q_valid && !out_valid_reg;
    assign done      = (state_reg == S_DRAIN) && c2_reg.valid && c2_reg.last_row
                       && c2_reg.last_term;

    assign mult_full = prod_reg * rd_data_reg;
    assign prod_ext  = DET_W'(prod_reg);
    assign acc_sum   = c2_reg.neg ? acc_reg - prod_ext : acc_reg + prod_ext;

    always_comb
    begin
        state_next        = state_reg;
        term_next         = term_reg;
        row_next          = row_reg;
        rbank_next        = rbank_reg;
        out_valid_next    = out_valid_reg;
        c1_next.valid     = (state_reg == S_ISSUE);
        c1_next.first     = (row_reg == '0);
        c1_next.last_row  = last_row;
        c1_next.neg       = perm[8];
        c1_next.last_term = last_term;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    term_next  = '0;
                    row_next   = '0;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (last_row)
                begin
                    row_next = '0;
                    if (last_term)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        term_next = term_reg + TERM_W'(1);
                    end
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (done)
                begin
                    out_valid_next = 1'b1;
                    rbank_next     = !rbank_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            term_reg      <= '0;
            row_reg       <= '0;
            rbank_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            c1_reg        <= '0;
            c2_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            term_reg      <= term_next;
            row_reg       <= row_next;
            rbank_reg     <= rbank_next;
            out_valid_reg <= out_valid_next;
            c1_reg        <= c1_next;
            c2_reg        <= c1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            matrix_mem[wr.bank][wr.addr[ADDR_W-1:0]] <= wr.data;
        end
        rd_data_reg <= matrix_mem[rbank_reg][rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (c1_reg.valid)
        begin
            prod_reg <= c1_reg.first ? PROD_W'(rd_data_reg) : mult_full[PROD_W-1:0];
        end
        if (start)
        begin
            acc_reg <= '0;
        end
        else if (c2_reg.valid && c2_reg.last_row)
        begin
            acc_reg <= acc_sum;
        end
        if (done)
        begin
            out_data_reg <= acc_sum;
        end
    end

    assign q_pop    = done;
    assign m_tvalid = out_valid_reg;
    assign m_det    = out_data_reg;

endmodule

// ----- sv/matrix_determinant.sv -----
// Top level of the matrix determinant block: front end, job queue and compute back end.
//
//   Channel  Direction  Word                               Handshake
//   cfg      in         cfg_data[2:0] = matrix_size        cfg_valid / cfg_ready
//   s        in         s_tdata[11:0] = entry              s_tvalid / s_tready
//   m        out        m_tdata[53:0] = determinant        m_tvalid / m_tready
//
// Entries load at one word per cycle, while the input is not stalled, into one of two matrix banks.
// The determinant is summed term by term through the single store read port and the one shared multiplier.
// Reset clears the load count, the job queue and the output; it needs no clearing pass.
// The input stalls while both banks hold matrices that are not yet finished,
// and in any cycle that carries a size write.
module matrix_determinant
    import mdet_pkg::*;
#(
    parameter int MAX_SIZE = MDET_MAX_SIZE
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [SIZE_W-1:0]    cfg_data,    // [2:0] matrix_size
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,     // [11:0] entry, zero fill above
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata      // [53:0] determinant, zero fill above
);

    store_wr_t wr;
    logic      q_push;
    logic      q_pop;
    logic      q_valid;
    logic      q_full;
    job_t      q_job;
    job_t      q_head;
    det_t      det;

    assign cfg_ready = 1'b1;

    mdet_front #(
        .MAX_SIZE (MAX_SIZE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_entry   (entry_t'(s_tdata[ENTRY_W-1:0])),
        .s_tready  (s_tready),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job),
        .wr        (wr)
    );

    mdet_queue #(
        .DEPTH (NUM_BANKS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head     (q_head),
        .valid    (q_valid),
        .full     (q_full)
    );

    mdet_back #(
        .MAX_SIZE (MAX_SIZE)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_det    (det)
    );

    assign m_tdata = {{(M_TDATA_W - DET_W){1'b0}}, det};

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("A finished matrix was queued while both banks were busy.");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("The back end retired a job that was never queued.");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(q_valid) && $past(q_pop))
        else $error("A determinant appeared without a retired job.");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench of the matrix determinant block, with random matrices and stalls.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mdet_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 120;
    localparam int RANDOM_WORDS  = 1350;

    typedef enum int {FILL_UNIFORM, FILL_EXTREME, FILL_SMALL, FILL_SINGULAR} fill_kind_e;

    class mdet_scoreboard;
        entry_t      cells [MDET_MAX_SIZE * MDET_MAX_SIZE];
        int unsigned dim;
        int unsigned loaded;
        det_t        expected_dets [$];
        int unsigned mismatches;

        function new();
            dim        = 2;
            loaded     = 0;
            mismatches = 0;
            foreach (cells[i])
            begin
                cells[i] = '0;
            end
        endfunction

        function void set_size(logic [SIZE_W-1:0] value);
            if (value < 2)
            begin
                dim = 2;
            end
            else if (value > MDET_MAX_SIZE)
            begin
                dim = MDET_MAX_SIZE;
            end
            else
            begin
                dim = value;
            end
            loaded = 0;
        endfunction

        // Cofactor expansion along the top remaining row over the unused columns.
        function longint expand(int unsigned row, logic [3:0] used);
            longint acc;
            longint term;
            bit     negate;
            acc    = 0;
            negate = 0;
            for (int c = 0; c < dim; c++)
            begin
                if (used[c])
                begin
                    continue;
                end
                if (row == dim - 1)
                begin
                    return longint'(cells[row * dim + c]);
                end
                term   = longint'(cells[row * dim + c]) * expand(row + 1, used | (4'b1 << c));
                acc    = negate ? acc - term : acc + term;
                negate = !negate;
            end
            return acc;
        endfunction

        function void note_entry(entry_t value);
            cells[loaded] = value;
            loaded++;
            if (loaded == dim * dim)
            begin
                loaded = 0;
                expected_dets.push_back(det_t'(expand(0, 4'b0)));
            end
        endfunction

        function void check_det(logic [M_TDATA_W-1:0] word);
            det_t got;
            det_t want;
            got = det_t'(word[DET_W-1:0]);
            if (expected_dets.size() == 0)
            begin
                mismatches++;
                $display("%0t: determinant %0d arrived with none expected", $time, got);
                return;
            end
            want = expected_dets.pop_front();
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: determinant mismatch, expected %0d, got %0d", $time, want, got);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [SIZE_W-1:0]    cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    bit             in_quiet;
    bit             out_quiet;
    int unsigned    entries_sent;
    int unsigned    quiet_cycles = 0;
    mdet_scoreboard sb = new();

    matrix_determinant #(
        .MAX_SIZE(MDET_MAX_SIZE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 95)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 60);
    endfunction

    task automatic send_entry(input entry_t value);
        int gap;
        gap = (in_quiet || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(S_TDATA_W - ENTRY_W){1'b0}}, value};
        do @(posedge clk); while (!s_tready);
        sb.note_entry(value);
        entries_sent++;
        @(negedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        sb.set_size(value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // A size write is only made once every determinant is out and the block has settled.
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (sb.expected_dets.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_matrix(input int unsigned n, input fill_kind_e kind);
        entry_t vals [MDET_MAX_SIZE * MDET_MAX_SIZE];
        int     pick;
        for (int i = 0; i < n * n; i++)
        begin
            case (kind)
                FILL_EXTREME:
                begin
                    pick = $urandom_range(0, 4);
                    case (pick)
                        0:       vals[i] = entry_t'(-2048);
                        1:       vals[i] = entry_t'(-1);
                        2:       vals[i] = entry_t'(0);
                        3:       vals[i] = entry_t'(1);
                        default: vals[i] = entry_t'(2047);
                    endcase
                end
                FILL_SMALL: vals[i] = entry_t'(int'($urandom_range(0, 6)) - 3);
                default:    vals[i] = entry_t'($urandom);
            endcase
        end
        if (kind == FILL_SINGULAR)
        begin
            for (int c = 0; c < n; c++)
            begin
                vals[(n - 1) * n + c] = vals[c];
            end
        end
        for (int i = 0; i < n * n; i++)
        begin
            send_entry(vals[i]);
        end
    endtask

    initial
    begin
        int         hold;
        m_tready = 1'b0;
        hold     = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
            end
            else if (out_quiet || !m_tready)
            begin
                m_tready = 1'b1;
                hold     = $urandom_range(0, 12);
            end
            else
            begin
                m_tready = 1'b0;
                hold     = idle_len() - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_det(m_tdata);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** matrix_determinant: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int unsigned directed_words;
        int unsigned n;
        int          r;
        fill_kind_e  kind;
        logic [SIZE_W-1:0] size_code;

        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        in_quiet     = 1'b0;
        out_quiet    = 1'b0;
        entries_sent = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The reset size is two.
        send_entry(entry_t'(-2048));
        send_entry(entry_t'(2047));
        send_entry(entry_t'(-2048));
        send_entry(entry_t'(-2048));

        // An oversized write acts as four; a sign pattern with orthogonal rows gives a
        // near-maximal result.
        wait_idle();
        write_size(3'd7);
        for (int i = 0; i < 16; i++)
        begin
            send_entry(($countones((i / 4) & (i % 4)) % 2) ? entry_t'(2047) : entry_t'(-2048));
        end

        // A size write in the middle of a matrix restarts the load.
        send_entry(entry_t'(1));
        send_entry(entry_t'(-1));
        wait_idle();
        write_size(3'd1);
        send_entry(entry_t'(0));
        send_entry(entry_t'(2047));
        send_entry(entry_t'(-1));
        send_entry(entry_t'(-2048));

        directed_words = entries_sent;
        while (entries_sent < directed_words + RANDOM_WORDS)
        begin
            wait_idle();
            size_code = ($urandom_range(0, 9) < 8) ? SIZE_W'($urandom_range(2, 4))
                                                   : SIZE_W'($urandom_range(0, 7));
            write_size(size_code);
            n         = sb.dim;
            in_quiet  = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 10))
            begin
                r = $urandom_range(0, 19);
                if (r < 10)
                begin
                    kind = FILL_UNIFORM;
                end
                else if (r < 14)
                begin
                    kind = FILL_EXTREME;
                end
                else if (r < 17)
                begin
                    kind = FILL_SMALL;
                end
                else
                begin
                    kind = FILL_SINGULAR;
                end
                send_matrix(n, kind);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, n * n - 1))
                begin
                    send_entry(entry_t'($urandom));
                end
            end
        end

        wait_idle();
        if (sb.mismatches == 0)
        begin
            $display("** matrix_determinant: PASSED **");
        end
        else
        begin
            $display("** matrix_determinant: FAILED **");
        end
        $finish;
    end

endmodule
